// File: rtl/bfce_pkg.sv
package bfce_pkg;

  localparam int unsigned FRAC_BITS  = 24;
  localparam int unsigned SIZE_W     = 21;
  localparam int unsigned HASH_W     = 6;
  localparam int unsigned EST_W      = 24;
  localparam int unsigned MANT_W     = 31;
  localparam int unsigned P_W        = 5;
  localparam int unsigned ACC_W      = 53;
  localparam int unsigned NUM_W      = 27;
  localparam int unsigned LIN_W      = 22;
  localparam int unsigned RATIO_STEPS = FRAC_BITS;
  localparam int unsigned SQ_STEPS    = FRAC_BITS;
  localparam int unsigned HDIV_STEPS  = NUM_W;

  localparam logic [23:0] LN2_Q24 = 24'd11629080;
  localparam logic [EST_W-1:0] EST_MAX = '1;

  typedef struct packed {
    logic                 lin;
    logic                 zero;
    logic                 full;
    logic [HASH_W-1:0]    h;
    logic [SIZE_W-1:0]    rem;
    logic [FRAC_BITS-1:0] quo;
    logic [P_W-1:0]       p;
    logic [MANT_W-1:0]    m;
    logic [FRAC_BITS-1:0] frac;
    logic [ACC_W-1:0]     acc;
    logic [LIN_W-1:0]     lin_num;
    logic [NUM_W-1:0]     num;
    logic [HASH_W-1:0]    hrem;
    logic [NUM_W-1:0]     hq;
  } item_t;

endpackage

// File: rtl/bfce_div_cell.sv
module bfce_div_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  bfce_pkg::item_t                item_i,
  input  logic [bfce_pkg::SIZE_W-1:0]    size_i,
  output logic                           valid_o,
  output bfce_pkg::item_t                item_o
);

  logic            valid_q;
  bfce_pkg::item_t item_q, item_d;
  logic [bfce_pkg::SIZE_W:0] rem2;
  logic            ge;

  always_comb begin
    rem2   = {item_i.rem, 1'b0};
    ge     = rem2 >= {1'b0, size_i};
    item_d = item_i;
    item_d.rem = ge ? bfce_pkg::SIZE_W'(rem2 - {1'b0, size_i})
                    : rem2[bfce_pkg::SIZE_W-1:0];
    item_d.quo = {item_i.quo[bfce_pkg::FRAC_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/bfce_sq_cell.sv
module bfce_sq_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  bfce_pkg::item_t item_i,
  output logic            valid_o,
  output bfce_pkg::item_t item_o
);

  localparam int unsigned MW = bfce_pkg::MANT_W;

  logic            valid_q;
  bfce_pkg::item_t item_q, item_d;
  logic [2*MW-1:0] prod;
  logic [MW:0]     sq;
  logic            bit_hi;

  always_comb begin
    prod   = (2*MW)'(item_i.m) * (2*MW)'(item_i.m);
    sq     = prod[2*MW-1:MW-1];
    bit_hi = sq[MW];
    item_d = item_i;
    item_d.m    = bit_hi ? sq[MW:1] : sq[MW-1:0];
    item_d.frac = {item_i.frac[bfce_pkg::FRAC_BITS-2:0], bit_hi};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/bfce_hdiv_cell.sv
module bfce_hdiv_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  bfce_pkg::item_t item_i,
  output logic            valid_o,
  output bfce_pkg::item_t item_o
);

  localparam int unsigned HW = bfce_pkg::HASH_W;
  localparam int unsigned NW = bfce_pkg::NUM_W;

  logic            valid_q;
  bfce_pkg::item_t item_q, item_d;
  logic [HW:0]     rem2;
  logic            ge;

  always_comb begin
    rem2   = {item_i.hrem, item_i.num[NW-1]};
    ge     = rem2 >= {1'b0, item_i.h};
    item_d = item_i;
    item_d.hrem = ge ? HW'(rem2 - {1'b0, item_i.h}) : rem2[HW-1:0];
    item_d.num  = {item_i.num[NW-2:0], 1'b0};
    item_d.hq   = {item_i.hq[NW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/bloom_filter_cardinality_estimate_top.sv
// Channel  Direction  Handshake                  Payload
// request  in         in_valid_i / in_stall_o    func_i, set_bits_i, hash_count_i
// result   out        out_valid_o / out_stall_i  estimate_o, saturated_o
// config   in         cfg_we_i                   cfg_wdata_i (filter_bits)
//
// One request per cycle while in_stall_o is low.
// The pipeline holds three cell chains: 24 ratio divide steps, 24 log2
// squaring steps and 27 divide-by-hash steps, plus entry, normalize,
// five log/multiply/round stages and the output register.
// Reset clears all valid bits and filter_bits; no clearing pass.
// A stalled result freezes the whole pipeline; in_stall_o follows it.
module bloom_filter_cardinality_estimate_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bfce_pkg::SIZE_W-1:0]         cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                func_i,
  input  logic [bfce_pkg::SIZE_W-1:0]         set_bits_i,
  input  logic [bfce_pkg::HASH_W-1:0]         hash_count_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bfce_pkg::EST_W-1:0]          estimate_o,
  output logic                                saturated_o
);

  localparam int unsigned RS = bfce_pkg::RATIO_STEPS;
  localparam int unsigned SS = bfce_pkg::SQ_STEPS;
  localparam int unsigned HS = bfce_pkg::HDIV_STEPS;

  logic [bfce_pkg::SIZE_W-1:0] filter_bits_q;
  logic en;

  logic            v0_q;
  bfce_pkg::item_t it0_q, it0_d;

  logic            dv [0:RS];
  bfce_pkg::item_t di [0:RS];
  logic            sv [0:SS];
  bfce_pkg::item_t si [0:SS];
  logic            hv [0:HS];
  bfce_pkg::item_t hi [0:HS];

  logic            nv_q, av_q, bv_q, cv_q, xv_q, ev_q;
  bfce_pkg::item_t ni_q, ai_q, bi_q, ci_q, xi_q, ei_q;
  bfce_pkg::item_t ni_d, ai_d, bi_d, ci_d, xi_d, ei_d;

  logic                         out_valid_q, saturated_q, saturated_d;
  logic [bfce_pkg::EST_W-1:0]   estimate_q, estimate_d;
  logic [bfce_pkg::NUM_W+23:0]  ysum;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_bits_q <= '0;
    end else if (cfg_we_i) begin
      filter_bits_q <= cfg_wdata_i;
    end
  end

  // entry; no set bits gives zero in both modes
  always_comb begin
    it0_d         = '0;
    it0_d.lin     = !func_i;
    it0_d.zero    = (filter_bits_q == '0) || (hash_count_i == '0) || (set_bits_i == '0);
    it0_d.full    = func_i && (set_bits_i >= filter_bits_q);
    it0_d.h       = hash_count_i;
    it0_d.rem     = filter_bits_q - set_bits_i;
    it0_d.lin_num = bfce_pkg::LIN_W'(set_bits_i) + bfce_pkg::LIN_W'(hash_count_i >> 1);
  end

  // normalize ratio to Q1.30
  always_comb begin
    ni_d = di[RS];
    ni_d.p = '0;
    for (int i = 0; i < int'(bfce_pkg::FRAC_BITS); i++) begin
      if (di[RS].quo[i]) begin
        ni_d.p = bfce_pkg::P_W'(i);
      end
    end
    if (di[RS].quo == '0) begin
      ni_d.full = 1'b1;
    end
    ni_d.m = bfce_pkg::MANT_W'(di[RS].quo) << (5'd30 - ni_d.p);
  end

  always_comb begin
    ai_d = si[SS];
    ai_d.acc = bfce_pkg::ACC_W'(
      (29'(5'(bfce_pkg::FRAC_BITS) - si[SS].p) << bfce_pkg::FRAC_BITS)
      - 29'(si[SS].frac));
    bi_d = ai_q;
    bi_d.acc = bfce_pkg::ACC_W'(ai_q.acc[28:0]) * bfce_pkg::ACC_W'(bfce_pkg::LN2_Q24);
    ci_d = bi_q;
    ci_d.acc = bfce_pkg::ACC_W'((bi_q.acc + (bfce_pkg::ACC_W'(1) << 23)) >> 24);
    xi_d = ci_q;
    xi_d.acc = bfce_pkg::ACC_W'(filter_bits_q) * bfce_pkg::ACC_W'(ci_q.acc[28:0]);
    ysum = 51'(xi_q.acc[49:0]) + (51'(xi_q.h) << 23);
    ei_d = xi_q;
    ei_d.num  = xi_q.lin ? bfce_pkg::NUM_W'(xi_q.lin_num) : ysum[50:24];
    ei_d.hrem = '0;
    ei_d.hq   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      nv_q <= 1'b0;
      av_q <= 1'b0;
      bv_q <= 1'b0;
      cv_q <= 1'b0;
      xv_q <= 1'b0;
      ev_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      nv_q <= dv[RS];
      av_q <= sv[SS];
      bv_q <= av_q;
      cv_q <= bv_q;
      xv_q <= cv_q;
      ev_q <= xv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it0_q <= it0_d;
      ni_q  <= ni_d;
      ai_q  <= ai_d;
      bi_q  <= bi_d;
      ci_q  <= ci_d;
      xi_q  <= xi_d;
      ei_q  <= ei_d;
    end
  end

  assign dv[0] = v0_q;
  assign di[0] = it0_q;
  assign sv[0] = nv_q;
  assign si[0] = ni_q;
  assign hv[0] = ev_q;
  assign hi[0] = ei_q;

  for (genvar g = 0; g < RS; g++) begin : g_ratio
    bfce_div_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .valid_i(dv[g]), .item_i(di[g]),
      .size_i(filter_bits_q), .valid_o(dv[g+1]), .item_o(di[g+1])
    );
  end

  for (genvar g = 0; g < SS; g++) begin : g_sq
    bfce_sq_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .valid_i(sv[g]), .item_i(si[g]),
      .valid_o(sv[g+1]), .item_o(si[g+1])
    );
  end

  for (genvar g = 0; g < HS; g++) begin : g_hdiv
    bfce_hdiv_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .valid_i(hv[g]), .item_i(hi[g]),
      .valid_o(hv[g+1]), .item_o(hi[g+1])
    );
  end

  always_comb begin
    estimate_d  = hi[HS].hq[bfce_pkg::EST_W-1:0];
    saturated_d = 1'b0;
    if (hi[HS].zero) begin
      estimate_d = '0;
    end else if (!hi[HS].lin && (hi[HS].full
               || (hi[HS].hq[bfce_pkg::NUM_W-1:bfce_pkg::EST_W] != '0))) begin
      estimate_d  = bfce_pkg::EST_MAX;
      saturated_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= hv[HS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      estimate_q  <= estimate_d;
      saturated_q <= saturated_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign estimate_o  = estimate_q;
  assign saturated_o = saturated_q;

`ifndef SYNTH
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> estimate_o == bfce_pkg::EST_MAX)
    else $error("saturated result without maximum estimate");

  a_ratio_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv[RS] && !di[RS].lin && !di[RS].zero && !di[RS].full
      |-> di[RS].rem < filter_bits_q)
    else $error("ratio remainder out of range");

  a_hdiv_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hv[HS] && !hi[HS].zero |-> hi[HS].hrem < hi[HS].h)
    else $error("hash divide remainder out of range");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && hv[HS] |=> out_valid_o)
    else $error("result lost at output register");
`endif

endmodule

// File: sim/bfce_estimate_checker.sv
`timescale 1ns / 100ps

module bfce_estimate_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bfce_pkg::SIZE_W-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         func_i,
  input  logic [bfce_pkg::SIZE_W-1:0]  set_bits_i,
  input  logic [bfce_pkg::HASH_W-1:0]  hash_count_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [bfce_pkg::EST_W-1:0]   estimate_i,
  input  logic                         saturated_i,
  output int                           fail_count_o,
  output int                           pending_o
);

  localparam logic [63:0] EST_LIMIT = 64'd16777215;
  localparam logic [63:0] LN2_Q24_W = 64'd11629080;

  typedef struct packed {
    logic                       sat;
    logic [bfce_pkg::EST_W-1:0] est;
  } estimate_t;

  logic [bfce_pkg::SIZE_W-1:0] filter_size;
  estimate_t expected_q[$];

  function automatic logic [63:0] neg_log2_q24(logic [63:0] r);
    int unsigned p;
    logic [63:0] m;
    logic [63:0] frac;
    p = 0;
    frac = 0;
    for (int i = 0; i < 64; i++) if (r[i]) p = i;
    if (p > 30) m = r >> (p - 30);
    else m = r << (30 - p);
    for (int i = 0; i < bfce_pkg::FRAC_BITS; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac = frac | 64'd1;
        m = m >> 1;
      end
    end
    return (64'(bfce_pkg::FRAC_BITS) << bfce_pkg::FRAC_BITS)
           - ((64'(p) << bfce_pkg::FRAC_BITS) + frac);
  endfunction

  function automatic estimate_t predict_estimate(logic fn,
                                                 logic [bfce_pkg::SIZE_W-1:0] ones,
                                                 logic [bfce_pkg::HASH_W-1:0] h,
                                                 logic [bfce_pkg::SIZE_W-1:0] size);
    estimate_t res;
    logic [63:0] est, r, ln, den;
    res = '0;
    if (size != 0 && h != 0) begin
      if (fn == 1'b0) begin
        est = (2 * 64'(ones) + 64'(h)) / (2 * 64'(h));
        res.est = est[bfce_pkg::EST_W-1:0];
      end else if (ones >= size) begin
        res = '{sat: 1'b1, est: bfce_pkg::EST_MAX};
      end else begin
        r = (64'(size - ones) << bfce_pkg::FRAC_BITS) / 64'(size);
        if (r == 0) begin
          res = '{sat: 1'b1, est: bfce_pkg::EST_MAX};
        end else begin
          ln = (neg_log2_q24(r) * LN2_Q24_W + (64'd1 << 23)) >> 24;
          den = 64'(h) << bfce_pkg::FRAC_BITS;
          est = (64'(size) * ln + (den >> 1)) / den;
          if (est > EST_LIMIT) res = '{sat: 1'b1, est: bfce_pkg::EST_MAX};
          else res.est = est[bfce_pkg::EST_W-1:0];
        end
      end
    end
    return res;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    estimate_t exp_res;
    if (!rst_ni) begin
      filter_size <= '0;
      fail_count_o <= 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) filter_size <= cfg_wdata_i;
      if (in_valid_i && !in_stall_i)
        expected_q.insert(expected_q.size(),
                          predict_estimate(func_i, set_bits_i, hash_count_i, filter_size));
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: estimate %0d saturated %0d", estimate_i, saturated_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_res = expected_q.pop_front();
          if (estimate_i !== exp_res.est || saturated_i !== exp_res.sat)
            fail_count_o <= fail_count_o + 1;
          if (estimate_i !== exp_res.est)
            $error("estimate: expected %0d actual %0d", exp_res.est, estimate_i);
          if (saturated_i !== exp_res.sat)
            $error("saturated: expected %0d actual %0d", exp_res.sat, saturated_i);
        end
      end
    end
  end

endmodule

// File: sim/bloom_filter_cardinality_estimate_top_tb.sv
`timescale 1ns / 100ps

module bloom_filter_cardinality_estimate_top_tb;

  localparam int WATCHDOG_CYCLES = 3000;
  localparam int DRAIN_CYCLES = 100;
  localparam int LONG_HOLD = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [bfce_pkg::SIZE_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic func_i = 1'b0;
  logic [bfce_pkg::SIZE_W-1:0] set_bits_i = '0;
  logic [bfce_pkg::HASH_W-1:0] hash_count_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [bfce_pkg::EST_W-1:0] estimate_o;
  logic saturated_o;
  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit hold_req = 1'b0;
  bit rand_gaps = 1'b1;
  logic [bfce_pkg::SIZE_W-1:0] cur_size = '0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  bloom_filter_cardinality_estimate_top uut (.*);

  bfce_estimate_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .func_i, .set_bits_i, .hash_count_i,
    .out_valid_i(out_valid_o), .out_stall_i, .estimate_i(estimate_o),
    .saturated_i(saturated_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!rand_gaps || r < 55) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver back-pressure
  initial begin
    int cnt;
    cnt = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        cnt = LONG_HOLD;
      end else if (cnt == 0) begin
        cnt = gap_len();
      end
      if (cnt > 0) cnt--;
      out_stall_i <= (cnt > 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_request(logic fn, logic [bfce_pkg::SIZE_W-1:0] ones,
                              logic [bfce_pkg::HASH_W-1:0] h);
    int gap;
    in_valid_i <= 1'b1;
    func_i <= fn;
    set_bits_i <= ones;
    hash_count_i <= h;
    do @(posedge clk_i); while (in_stall_o);
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    if (in_valid_i) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_size(logic [bfce_pkg::SIZE_W-1:0] size);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= size;
    cur_size = size;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic directed_requests();
    logic [bfce_pkg::SIZE_W-1:0] s;
    s = cur_size;
    for (int f = 0; f < 2; f++) begin
      send_request(f[0], '0, 6'd1);
      send_request(f[0], s - 1, 6'd1);
      send_request(f[0], s, 6'd32);
      send_request(f[0], s + 1, 6'd3);
      send_request(f[0], '1, 6'd1);
      send_request(f[0], s >> 1, 6'd0);
      send_request(f[0], s >> 2, 6'd63);
      send_request(f[0], 21'd1, 6'd7);
    end
  endtask

  task automatic random_requests(int n);
    logic [bfce_pkg::SIZE_W-1:0] ones;
    logic [bfce_pkg::HASH_W-1:0] h;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r < 6 && cur_size != 0)
        ones = bfce_pkg::SIZE_W'($urandom_range(0, cur_size - 1));
      else if (r < 8) ones = cur_size - bfce_pkg::SIZE_W'($urandom_range(0, 3));
      else ones = bfce_pkg::SIZE_W'($urandom);
      h = ($urandom_range(0, 9) == 0) ? bfce_pkg::HASH_W'($urandom)
                                      : bfce_pkg::HASH_W'($urandom_range(1, 32));
      send_request(1'($urandom), ones, h);
    end
  endtask

  initial begin
    logic [bfce_pkg::SIZE_W-1:0] sizes[8];
    sizes = '{21'd0, 21'd1, 21'd2, 21'd1000, 21'd1048576, 21'h1FFFFF,
              21'd65536, 21'd0};
    sizes[7] = bfce_pkg::SIZE_W'($urandom);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_requests();
    drain_results();
    for (int k = 1; k < 8; k++) begin
      write_size(sizes[k]);
      directed_requests();
      random_requests(60);
      drain_results();
    end
    // long receiver hold with back-to-back requests
    rand_gaps = 1'b0;
    hold_req = 1'b1;
    random_requests(150);
    rand_gaps = 1'b1;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
